### hw/rtl/obb_closest_point_distance_defines.svh
// Assertion macros shared by the closest-point RTL.
`ifndef OBB_CLOSEST_POINT_DISTANCE_DEFINES_SVH
`define OBB_CLOSEST_POINT_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OBB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/obbcpd_pkg.sv
// Package: widths, register codes, word types and the square-root step.
`timescale 1ns / 1ps

package obbcpd_pkg;

  // Base formats
  localparam int COORD_WIDTH    = 24;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int AXIS_WIDTH     = AXIS_FRAC_BITS + 2;
  localparam int HALF_WIDTH     = COORD_WIDTH - 1;
  localparam int CFG_WIDTH      = (COORD_WIDTH > AXIS_WIDTH) ? COORD_WIDTH : AXIS_WIDTH;
  localparam int DIST_SQ_WIDTH  = 51;

  // Square root: one result bit per stage
  localparam int ROOT_STEPS     = (DIST_SQ_WIDTH + 1) / 2;
  localparam int DIST_RES_WIDTH = ROOT_STEPS;
  localparam int RAD_WIDTH      = 2 * ROOT_STEPS;
  localparam int REM_WIDTH      = ROOT_STEPS + 2;

  // Datapath widths
  localparam int DIFF_WIDTH       = COORD_WIDTH + 1;
  localparam int PROJ_PROD_WIDTH  = DIFF_WIDTH + AXIS_WIDTH;
  localparam int PROJ_SUM_WIDTH   = PROJ_PROD_WIDTH + 1;
  localparam int LOCAL_WIDTH      = PROJ_SUM_WIDTH - AXIS_FRAC_BITS;
  localparam int BUILD_PROD_WIDTH = AXIS_WIDTH + COORD_WIDTH;
  localparam int BUILD_SUM_WIDTH  = BUILD_PROD_WIDTH + 1;
  localparam int OFFSET_WIDTH     = BUILD_SUM_WIDTH - AXIS_FRAC_BITS;
  localparam int POINT_WIDTH      = OFFSET_WIDTH + 1;
  localparam int SQ_FULL_WIDTH    = 2 * DIFF_WIDTH;
  localparam int SQUARE_WIDTH     = 2 * COORD_WIDTH;
  localparam int SQ_SUM_WIDTH     = SQUARE_WIDTH + 1;
  localparam int SAT_WIDTH        = (SQ_SUM_WIDTH > DIST_SQ_WIDTH) ? SQ_SUM_WIDTH
                                                                   : DIST_SQ_WIDTH;
  localparam int ROOT_CHECK_WIDTH = 2 * DIST_RES_WIDTH + 2;

  // Pipeline depth
  localparam int FRONT_STAGES = 9;
  localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_STEPS;

  localparam logic [AXIS_WIDTH-1:0]    AXIS_ONE    = AXIS_WIDTH'(1) << AXIS_FRAC_BITS;
  localparam logic [DIST_SQ_WIDTH-1:0] DIST_SQ_MAX = '1;

  // Register indexes
  localparam int REG_INDEX_WIDTH = 3;
  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_AXIS_U_X    = 3'd2,
    REG_AXIS_U_Y    = 3'd3,
    REG_AXIS_V_X    = 3'd4,
    REG_AXIS_V_Y    = 3'd5,
    REG_HALF_WIDTH  = 3'd6,
    REG_HALF_HEIGHT = 3'd7
  } cfg_reg_t;

  // One result word
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] closest_x;
    logic signed [COORD_WIDTH-1:0] closest_y;
    logic [DIST_SQ_WIDTH-1:0]      dist_sq;
    logic [DIST_RES_WIDTH-1:0]     dist_res;
  } result_t;

  // Digit-by-digit square root state
  typedef struct packed {
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_STEPS-1:0] root;
    logic [RAD_WIDTH-1:0]  rad;
  } root_state_t;

  // Root stage word: root state plus the point that rides along
  typedef struct packed {
    root_state_t                   st;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic [DIST_SQ_WIDTH-1:0]      dsq;
  } root_stage_t;

  // One restoring step: bring in two radicand bits, try root*4+1
  function automatic root_state_t root_step(input root_state_t cur);
    root_state_t          nxt;
    logic [REM_WIDTH-1:0] shifted;
    logic [REM_WIDTH-1:0] trial;
    shifted = {cur.rem[REM_WIDTH-3:0], cur.rad[RAD_WIDTH-1 -: 2]};
    trial   = {cur.root, 2'b01};
    nxt.rad = cur.rad << 2;
    if (shifted >= trial) begin
      nxt.rem  = shifted - trial;
      nxt.root = {cur.root[ROOT_STEPS-2:0], 1'b1};
    end else begin
      nxt.rem  = shifted;
      nxt.root = {cur.root[ROOT_STEPS-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

### hw/rtl/obb_closest_point_distance.sv
// Top level: closest point on a 2D oriented box, squared distance and its root.
// A word passes through 9 arithmetic stages and 26 square-root stages at one
// result bit each, then through the output register.
// Throughput: one word per cycle; a stalled output parks one word in a skid
// register, after which in_stall is raised until the skid drains.
// Reset clears all valid bits and loads the registers with the unit box axes.
`timescale 1ns / 1ps
`include "obb_closest_point_distance_defines.svh"

module obb_closest_point_distance (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  obbcpd_pkg::cfg_reg_t                     cfg_index,
  input  logic [obbcpd_pkg::CFG_WIDTH-1:0]         cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [obbcpd_pkg::COORD_WIDTH-1:0] query_x,
  input  logic signed [obbcpd_pkg::COORD_WIDTH-1:0] query_y,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [obbcpd_pkg::COORD_WIDTH-1:0] closest_x,
  output logic signed [obbcpd_pkg::COORD_WIDTH-1:0] closest_y,
  output logic [obbcpd_pkg::DIST_SQ_WIDTH-1:0]     dist_sq,
  output logic [obbcpd_pkg::DIST_RES_WIDTH-1:0]    dist_res
);
  import obbcpd_pkg::*;

  // Configuration registers
  logic signed [COORD_WIDTH-1:0] center_x, center_y;
  logic signed [AXIS_WIDTH-1:0]  axis_u_x, axis_u_y, axis_v_x, axis_v_y;
  logic [HALF_WIDTH-1:0]         half_width, half_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      axis_u_x    <= AXIS_ONE;
      axis_u_y    <= '0;
      axis_v_x    <= '0;
      axis_v_y    <= AXIS_ONE;
      half_width  <= '0;
      half_height <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:    center_x    <= cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[COORD_WIDTH-1:0];
        REG_AXIS_U_X:    axis_u_x    <= cfg_data[AXIS_WIDTH-1:0];
        REG_AXIS_U_Y:    axis_u_y    <= cfg_data[AXIS_WIDTH-1:0];
        REG_AXIS_V_X:    axis_v_x    <= cfg_data[AXIS_WIDTH-1:0];
        REG_AXIS_V_Y:    axis_v_y    <= cfg_data[AXIS_WIDTH-1:0];
        REG_HALF_WIDTH:  half_width  <= cfg_data[HALF_WIDTH-1:0];
        REG_HALF_HEIGHT: half_height <= cfg_data[HALF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: whole pipe moves unless the skid register is full
  logic en;
  logic skid_valid;
  logic [PIPE_STAGES:1] pipe_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (en) begin
      pipe_valid <= {pipe_valid[PIPE_STAGES-1:1], in_valid};
    end
  end

  // Stage registers
  logic signed [COORD_WIDTH-1:0]      q1_x, q1_y, q2_x, q2_y, q3_x, q3_y;
  logic signed [COORD_WIDTH-1:0]      q4_x, q4_y, q5_x, q5_y, q6_x, q6_y;
  logic signed [DIFF_WIDTH-1:0]       d1_x, d1_y;
  logic signed [PROJ_PROD_WIDTH-1:0]  pux2, puy2, pvx2, pvy2;
  logic signed [COORD_WIDTH-1:0]      lu3, lv3;
  logic signed [BUILD_PROD_WIDTH-1:0] bux4, bvx4, buy4, bvy4;
  logic signed [OFFSET_WIDTH-1:0]     ox5, oy5;
  logic signed [COORD_WIDTH-1:0]      p6_x, p6_y, p7_x, p7_y, p8_x, p8_y, p9_x, p9_y;
  logic signed [DIFF_WIDTH-1:0]       e7_x, e7_y;
  logic [SQUARE_WIDTH-1:0]            s8_x, s8_y;
  logic [DIST_SQ_WIDTH-1:0]           dsq9;

  // Projection sums, shift and clamp to the half extents
  logic signed [PROJ_SUM_WIDTH-1:0]  proj_u, proj_v;
  logic signed [LOCAL_WIDTH-1:0]     loc_u, loc_v, hw_pos, hh_pos, clamp_u, clamp_v;
  logic signed [BUILD_SUM_WIDTH-1:0] build_x, build_y;
  logic signed [POINT_WIDTH-1:0]     pt_x, pt_y;
  logic                              pt_x_fits, pt_y_fits;
  logic signed [COORD_WIDTH-1:0]     pt_x_sat, pt_y_sat;
  logic signed [SQ_FULL_WIDTH-1:0]   sq_full_x, sq_full_y;
  logic [SQ_SUM_WIDTH-1:0]           sq_sum;
  logic [SAT_WIDTH-1:0]              sq_wide;

  always_comb begin
    proj_u = PROJ_SUM_WIDTH'(pux2) + PROJ_SUM_WIDTH'(puy2);
    proj_v = PROJ_SUM_WIDTH'(pvx2) + PROJ_SUM_WIDTH'(pvy2);
    loc_u  = LOCAL_WIDTH'(proj_u >>> AXIS_FRAC_BITS);
    loc_v  = LOCAL_WIDTH'(proj_v >>> AXIS_FRAC_BITS);
    hw_pos = LOCAL_WIDTH'($signed({1'b0, half_width}));
    hh_pos = LOCAL_WIDTH'($signed({1'b0, half_height}));
    if (loc_u > hw_pos)       clamp_u = hw_pos;
    else if (loc_u < -hw_pos) clamp_u = -hw_pos;
    else                      clamp_u = loc_u;
    if (loc_v > hh_pos)       clamp_v = hh_pos;
    else if (loc_v < -hh_pos) clamp_v = -hh_pos;
    else                      clamp_v = loc_v;
  end

  // Rebuilt point: center plus offset, saturated to the coordinate range
  always_comb begin
    build_x   = BUILD_SUM_WIDTH'(bux4) + BUILD_SUM_WIDTH'(bvx4);
    build_y   = BUILD_SUM_WIDTH'(buy4) + BUILD_SUM_WIDTH'(bvy4);
    pt_x      = POINT_WIDTH'(center_x) + POINT_WIDTH'(ox5);
    pt_y      = POINT_WIDTH'(center_y) + POINT_WIDTH'(oy5);
    pt_x_fits = (pt_x[POINT_WIDTH-1:COORD_WIDTH-1] == '0) ||
                (pt_x[POINT_WIDTH-1:COORD_WIDTH-1] == '1);
    pt_y_fits = (pt_y[POINT_WIDTH-1:COORD_WIDTH-1] == '0) ||
                (pt_y[POINT_WIDTH-1:COORD_WIDTH-1] == '1);
    pt_x_sat  = pt_x_fits ? pt_x[COORD_WIDTH-1:0]
                          : {pt_x[POINT_WIDTH-1], {(COORD_WIDTH-1){!pt_x[POINT_WIDTH-1]}}};
    pt_y_sat  = pt_y_fits ? pt_y[COORD_WIDTH-1:0]
                          : {pt_y[POINT_WIDTH-1], {(COORD_WIDTH-1){!pt_y[POINT_WIDTH-1]}}};
  end

  // Squares and saturated sum
  always_comb begin
    sq_full_x = SQ_FULL_WIDTH'(e7_x) * SQ_FULL_WIDTH'(e7_x);
    sq_full_y = SQ_FULL_WIDTH'(e7_y) * SQ_FULL_WIDTH'(e7_y);
    sq_sum    = SQ_SUM_WIDTH'(s8_x) + SQ_SUM_WIDTH'(s8_y);
    sq_wide   = SAT_WIDTH'(sq_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offset from center
      q1_x <= query_x;
      q1_y <= query_y;
      d1_x <= DIFF_WIDTH'(query_x) - DIFF_WIDTH'(center_x);
      d1_y <= DIFF_WIDTH'(query_y) - DIFF_WIDTH'(center_y);
      // stage 2: dot product terms
      q2_x <= q1_x;
      q2_y <= q1_y;
      pux2 <= PROJ_PROD_WIDTH'(d1_x) * PROJ_PROD_WIDTH'(axis_u_x);
      puy2 <= PROJ_PROD_WIDTH'(d1_y) * PROJ_PROD_WIDTH'(axis_u_y);
      pvx2 <= PROJ_PROD_WIDTH'(d1_x) * PROJ_PROD_WIDTH'(axis_v_x);
      pvy2 <= PROJ_PROD_WIDTH'(d1_y) * PROJ_PROD_WIDTH'(axis_v_y);
      // stage 3: clamped local coordinates
      q3_x <= q2_x;
      q3_y <= q2_y;
      lu3  <= COORD_WIDTH'(clamp_u);
      lv3  <= COORD_WIDTH'(clamp_v);
      // stage 4: rebuild terms
      q4_x <= q3_x;
      q4_y <= q3_y;
      bux4 <= BUILD_PROD_WIDTH'(axis_u_x) * BUILD_PROD_WIDTH'(lu3);
      bvx4 <= BUILD_PROD_WIDTH'(axis_v_x) * BUILD_PROD_WIDTH'(lv3);
      buy4 <= BUILD_PROD_WIDTH'(axis_u_y) * BUILD_PROD_WIDTH'(lu3);
      bvy4 <= BUILD_PROD_WIDTH'(axis_v_y) * BUILD_PROD_WIDTH'(lv3);
      // stage 5: offset from center, floored
      q5_x <= q4_x;
      q5_y <= q4_y;
      ox5  <= OFFSET_WIDTH'(build_x >>> AXIS_FRAC_BITS);
      oy5  <= OFFSET_WIDTH'(build_y >>> AXIS_FRAC_BITS);
      // stage 6: saturated closest point
      q6_x <= q5_x;
      q6_y <= q5_y;
      p6_x <= pt_x_sat;
      p6_y <= pt_y_sat;
      // stage 7: error vector
      p7_x <= p6_x;
      p7_y <= p6_y;
      e7_x <= DIFF_WIDTH'(p6_x) - DIFF_WIDTH'(q6_x);
      e7_y <= DIFF_WIDTH'(p6_y) - DIFF_WIDTH'(q6_y);
      // stage 8: squares
      p8_x <= p7_x;
      p8_y <= p7_y;
      s8_x <= sq_full_x[SQUARE_WIDTH-1:0];
      s8_y <= sq_full_y[SQUARE_WIDTH-1:0];
      // stage 9: squared distance
      p9_x <= p8_x;
      p9_y <= p8_y;
      dsq9 <= (sq_wide > SAT_WIDTH'(DIST_SQ_MAX)) ? DIST_SQ_MAX
                                                  : DIST_SQ_WIDTH'(sq_wide);
    end
  end

  // Square-root pipeline, one result bit per stage
  root_stage_t root_in;
  root_stage_t rs [1:ROOT_STEPS];

  assign root_in = '{st:  '{rem: '0, root: '0, rad: RAD_WIDTH'(dsq9)},
                     px:  p9_x,
                     py:  p9_y,
                     dsq: dsq9};

  for (genvar k = 1; k <= ROOT_STEPS; k++) begin : g_root
    root_stage_t src;
    if (k == 1) begin : g_first
      assign src = root_in;
    end else begin : g_next
      assign src = rs[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rs[k] <= '{st: root_step(src.st), px: src.px, py: src.py, dsq: src.dsq};
      end
    end
  end

  // Output register with one skid word
  result_t res_last, main_word, skid_word;
  logic    take, push;
  logic    out_valid_next, skid_valid_next;
  logic    load_main_pipe, load_main_skid, load_skid;

  assign res_last = '{closest_x: rs[ROOT_STEPS].px,
                      closest_y: rs[ROOT_STEPS].py,
                      dist_sq:   rs[ROOT_STEPS].dsq,
                      dist_res:  rs[ROOT_STEPS].st.root};

  always_comb begin
    take            = out_valid && !out_stall;
    push            = en && pipe_valid[PIPE_STAGES];
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    load_main_pipe  = 1'b0;
    load_main_skid  = 1'b0;
    load_skid       = 1'b0;
    if (skid_valid) begin
      if (take) begin
        load_main_skid  = 1'b1;
        skid_valid_next = 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        load_main_pipe = 1'b1;
        out_valid_next = 1'b1;
      end else begin
        load_skid       = 1'b1;
        skid_valid_next = 1'b1;
      end
    end else if (take) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main_pipe) begin
      main_word <= res_last;
    end else if (load_main_skid) begin
      main_word <= skid_word;
    end
    if (load_skid) begin
      skid_word <= res_last;
    end
  end

  assign closest_x = main_word.closest_x;
  assign closest_y = main_word.closest_y;
  assign dist_sq   = main_word.dist_sq;
  assign dist_res  = main_word.dist_res;

  // Checks
  `OBB_ASSERT_NEXT(a_accept_tracked, in_valid && !in_stall, pipe_valid[1], "accepted word lost at entry")
  `OBB_ASSERT_IMPL(a_skid_has_main, skid_valid, out_valid, "skid word held with empty output")
  `OBB_ASSERT_IMPL(a_skid_cause, $rose(skid_valid), $past(out_valid && out_stall), "skid filled without a stalled output")
  `OBB_ASSERT_IMPL(a_root_low, out_valid, ROOT_CHECK_WIDTH'(dist_res) * ROOT_CHECK_WIDTH'(dist_res) <= ROOT_CHECK_WIDTH'(dist_sq), "root too large")
  `OBB_ASSERT_IMPL(a_root_high, out_valid, (ROOT_CHECK_WIDTH'(dist_res) + 1'b1) * (ROOT_CHECK_WIDTH'(dist_res) + 1'b1) > ROOT_CHECK_WIDTH'(dist_sq), "root too small")

endmodule

### tb/tb_top.sv
// Testbench for the oriented-box closest-point and distance block.
`timescale 1ns / 1ps

module tb_top;
  import obbcpd_pkg::*;

  localparam int COORD_MAX       = 8388607;
  localparam int COORD_MIN       = -8388608;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 222;

  // Directed stimulus rows: either a query or a register write
  typedef enum logic {ROW_QUERY, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    cfg_reg_t                      idx;
    logic [CFG_WIDTH-1:0]          data;
    logic signed [COORD_WIDTH-1:0] qx;
    logic signed [COORD_WIDTH-1:0] qy;
    bit                            typed;
    result_t                       want;
  } dir_row_t;

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_write;
  cfg_reg_t                               cfg_index;
  logic [CFG_WIDTH-1:0]                   cfg_data;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [COORD_WIDTH-1:0]          query_x;
  logic signed [COORD_WIDTH-1:0]          query_y;
  logic                                   out_valid;
  logic                                   out_stall;
  logic signed [COORD_WIDTH-1:0]          closest_x;
  logic signed [COORD_WIDTH-1:0]          closest_y;
  logic [DIST_SQ_WIDTH-1:0]               dist_sq;
  logic [DIST_RES_WIDTH-1:0]              dist_res;

  // Shadow copy of the box registers
  logic signed [COORD_WIDTH-1:0] box_cx, box_cy;
  logic signed [AXIS_WIDTH-1:0]  axis_ux, axis_uy, axis_vx, axis_vy;
  logic [HALF_WIDTH-1:0]         half_w, half_h;

  result_t  pending_points[$];
  dir_row_t dir_rows[$];

  int  n_queries;
  int  n_checked;
  int  n_errors;
  int  n_writes;
  int  n_boxes;
  bit  hold_req;

  obb_closest_point_distance dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .query_x   (query_x),
    .query_y   (query_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .closest_x (closest_x),
    .closest_y (closest_y),
    .dist_sq   (dist_sq),
    .dist_res  (dist_res)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint clamp_l(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Digit-by-digit floor square root
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    longint unsigned rem;
    r   = 0;
    rem = n;
    b   = 64'h4000_0000_0000_0000;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Closest box point to a query, with squared distance and its root
  function automatic result_t predict_closest(input logic signed [COORD_WIDTH-1:0] qx,
                                              input logic signed [COORD_WIDTH-1:0] qy);
    result_t         r;
    longint          dx, dy, lu, lv, px, py, ex, ey, hwl, hhl;
    longint unsigned dsq;
    dx  = longint'(qx) - longint'(box_cx);
    dy  = longint'(qy) - longint'(box_cy);
    hwl = longint'(half_w);
    hhl = longint'(half_h);
    // local coordinates, floor shift, clamped to the extents
    lu = clamp_l((dx * longint'(axis_ux) + dy * longint'(axis_uy)) >>> AXIS_FRAC_BITS,
                 -hwl, hwl);
    lv = clamp_l((dx * longint'(axis_vx) + dy * longint'(axis_vy)) >>> AXIS_FRAC_BITS,
                 -hhl, hhl);
    // rebuild and saturate
    px = clamp_l(longint'(box_cx)
                 + ((longint'(axis_ux) * lu + longint'(axis_vx) * lv) >>> AXIS_FRAC_BITS),
                 COORD_MIN, COORD_MAX);
    py = clamp_l(longint'(box_cy)
                 + ((longint'(axis_uy) * lu + longint'(axis_vy) * lv) >>> AXIS_FRAC_BITS),
                 COORD_MIN, COORD_MAX);
    ex  = px - longint'(qx);
    ey  = py - longint'(qy);
    dsq = longint'(ex * ex) + longint'(ey * ey);
    if (dsq > longint'(DIST_SQ_MAX)) dsq = DIST_SQ_MAX;
    r.closest_x = px[COORD_WIDTH-1:0];
    r.closest_y = py[COORD_WIDTH-1:0];
    r.dist_sq   = dsq[DIST_SQ_WIDTH-1:0];
    r.dist_res  = DIST_RES_WIDTH'(floor_root(dsq));
    return r;
  endfunction

  function automatic void add_query(input int x, input int y);
    dir_row_t row;
    row.kind  = ROW_QUERY;
    row.idx   = REG_CENTER_X;
    row.data  = '0;
    row.qx    = x;
    row.qy    = y;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  // Query whose result is written out by hand
  function automatic void add_typed(input int x, input int y, input int cx, input int cy,
                                    input longint dsq, input int root);
    dir_row_t row;
    row.kind           = ROW_QUERY;
    row.idx            = REG_CENTER_X;
    row.data           = '0;
    row.qx             = x;
    row.qy             = y;
    row.typed          = 1'b1;
    row.want.closest_x = cx;
    row.want.closest_y = cy;
    row.want.dist_sq   = dsq;
    row.want.dist_res  = root;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_reg_t idx, input logic [CFG_WIDTH-1:0] data);
    dir_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = data;
    row.qx    = '0;
    row.qy    = '0;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  // Register write, called at a falling edge with the block idle
  task automatic cfg_put(input cfg_reg_t idx, input logic [CFG_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CENTER_X:    box_cx  = data[COORD_WIDTH-1:0];
      REG_CENTER_Y:    box_cy  = data[COORD_WIDTH-1:0];
      REG_AXIS_U_X:    axis_ux = data[AXIS_WIDTH-1:0];
      REG_AXIS_U_Y:    axis_uy = data[AXIS_WIDTH-1:0];
      REG_AXIS_V_X:    axis_vx = data[AXIS_WIDTH-1:0];
      REG_AXIS_V_Y:    axis_vy = data[AXIS_WIDTH-1:0];
      REG_HALF_WIDTH:  half_w  = data[HALF_WIDTH-1:0];
      REG_HALF_HEIGHT: half_h  = data[HALF_WIDTH-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  // Offer one query word and hold it until accepted; ends on a falling edge
  task automatic offer_query(input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input bit typed, input result_t want);
    in_valid <= 1'b1;
    query_x  <= x;
    query_y  <= y;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(typed ? want : predict_closest(x, y));
    n_queries++;
    @(negedge clk);
  endtask

  function automatic logic [CFG_WIDTH-1:0] extreme_axis();
    case ($urandom_range(0, 3))
      0:       return CFG_WIDTH'(16'sd16384);
      1:       return CFG_WIDTH'(-16'sd16384);
      2:       return CFG_WIDTH'(16'h8000);
      default: return CFG_WIDTH'(16'h7FFF);
    endcase
  endfunction

  // New box: typical, largest, smallest, or raw random register bits
  task automatic load_box(input int style);
    logic [CFG_WIDTH-1:0] v[8];
    case (style)
      0: begin
        v[0] = $urandom_range(0, 1 << 21) - (1 << 20);
        v[1] = $urandom_range(0, 1 << 21) - (1 << 20);
        v[2] = $urandom_range(0, 32768) - 16384;
        v[3] = $urandom_range(0, 32768) - 16384;
        v[4] = $urandom_range(0, 32768) - 16384;
        v[5] = $urandom_range(0, 32768) - 16384;
        v[6] = $urandom_range(0, 1 << 16);
        v[7] = $urandom_range(0, 1 << 16);
      end
      1: begin
        v[0] = COORD_MAX;
        v[1] = COORD_MIN;
        v[2] = extreme_axis();
        v[3] = extreme_axis();
        v[4] = extreme_axis();
        v[5] = extreme_axis();
        v[6] = 24'h7FFFFF;
        v[7] = 24'h7FFFFF;
      end
      2: begin
        v[0] = COORD_MIN;
        v[1] = COORD_MAX;
        v[2] = $urandom_range(0, 1) ? AXIS_ONE : 0;
        v[3] = $urandom_range(0, 1) ? AXIS_ONE : 0;
        v[4] = $urandom_range(0, 1) ? AXIS_ONE : 0;
        v[5] = $urandom_range(0, 1) ? AXIS_ONE : 0;
        v[6] = $urandom_range(0, 1);
        v[7] = $urandom_range(0, 1);
      end
      default: begin
        foreach (v[i]) v[i] = $urandom;
      end
    endcase
    cfg_put(REG_CENTER_X,    v[0]);
    cfg_put(REG_CENTER_Y,    v[1]);
    cfg_put(REG_AXIS_U_X,    v[2]);
    cfg_put(REG_AXIS_U_Y,    v[3]);
    cfg_put(REG_AXIS_V_X,    v[4]);
    cfg_put(REG_AXIS_V_Y,    v[5]);
    cfg_put(REG_HALF_WIDTH,  v[6]);
    cfg_put(REG_HALF_HEIGHT, v[7]);
    n_boxes++;
  endtask

  // Receiver: random stall runs, plus one long hold-off on request
  initial begin : receiver
    int run_left;
    int stall_pct;
    run_left  = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        run_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {closest_x, closest_y, dist_sq, dist_res};
      if (pending_points.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected word: x=%0d y=%0d dsq=%0d root=%0d",
                   got.closest_x, got.closest_y, got.dist_sq, got.dist_res);
      end else begin
        want = pending_points.pop_front();
        n_checked++;
        if (got.closest_x !== want.closest_x || got.closest_y !== want.closest_y ||
            got.dist_sq !== want.dist_sq || got.dist_res !== want.dist_res) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch on word %0d: expected x=%0d y=%0d dsq=%0d root=%0d, got x=%0d y=%0d dsq=%0d root=%0d",
                     n_checked, want.closest_x, want.closest_y, want.dist_sq,
                     want.dist_res, got.closest_x, got.closest_y, got.dist_sq,
                     got.dist_res);
        end
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int                            burst_left;
    int                            gap;
    int                            near_span;
    logic signed [COORD_WIDTH-1:0] x, y;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_CENTER_X;
    cfg_data   = '0;
    in_valid   = 1'b0;
    query_x    = '0;
    query_y    = '0;
    hold_req   = 1'b0;
    n_queries  = 0;
    n_checked  = 0;
    n_errors   = 0;
    n_writes   = 0;
    n_boxes    = 1;
    box_cx     = '0;
    box_cy     = '0;
    axis_ux    = AXIS_ONE;
    axis_uy    = '0;
    axis_vx    = '0;
    axis_vy    = AXIS_ONE;
    half_w     = '0;
    half_h     = '0;
    burst_left = 0;

    // Reset box: unit axes, zero extents, so every point snaps to the origin
    add_typed(0, 0, 0, 0, 0, 0);
    add_typed(256, -512, 0, 0, 327680, 572);
    add_typed(COORD_MIN, COORD_MIN, 0, 0, 64'd140737488355328, 11863283);
    add_query(COORD_MAX, COORD_MAX);
    add_query(COORD_MAX, COORD_MIN);
    add_query(-1, 1);
    // 10 x 5 box off center
    add_cfg(REG_CENTER_X, 24'd4096);
    add_cfg(REG_CENTER_Y, -24'sd4096);
    add_cfg(REG_HALF_WIDTH, 24'd2560);
    add_cfg(REG_HALF_HEIGHT, 24'd1280);
    add_typed(4096, -4096, 4096, -4096, 0, 0);
    add_typed(6912, -4096, 6656, -4096, 65536, 256);
    add_query(-20000, 3000);
    // same box turned by 45 degrees
    add_cfg(REG_AXIS_U_X, 24'd11585);
    add_cfg(REG_AXIS_U_Y, 24'd11585);
    add_cfg(REG_AXIS_V_X, -24'sd11585);
    add_cfg(REG_AXIS_V_Y, 24'd11585);
    add_query(10000, 2000);
    add_query(-3000, -9000);
    // non-unit axes and full extents push the rebuilt point into saturation
    add_cfg(REG_CENTER_X, 24'h7FFFFF);
    add_cfg(REG_AXIS_U_X, 24'h008000);
    add_cfg(REG_HALF_WIDTH, 24'h7FFFFF);
    add_cfg(REG_HALF_HEIGHT, 24'h7FFFFF);
    add_query(COORD_MIN, 0);
    add_query(COORD_MAX, COORD_MIN);
    add_query(24'h555555, 24'hAAAAAA);
    add_query(24'hAAAAAA, 24'h555555);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        in_valid <= 1'b0;
        wait_drained();
        cfg_put(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        offer_query(dir_rows[i].qx, dir_rows[i].qy, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    in_valid <= 1'b0;
    n_boxes++;

    // Random part: a new box per phase, queries mostly around the box
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      load_box(ph % 4);
      if (ph == 1) hold_req = 1'b1;
      near_span = (half_w > half_h) ? int'(half_w) : int'(half_h);
      near_span = near_span * 2 + 2048;
      if (near_span > (1 << 23)) near_span = 1 << 23;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left--;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            x = int'(box_cx) + int'($urandom_range(0, 2 * near_span)) - near_span;
            y = int'(box_cy) + int'($urandom_range(0, 2 * near_span)) - near_span;
          end
          6, 7, 8: begin
            x = $urandom;
            y = $urandom;
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       x = COORD_MAX;
              1:       x = COORD_MIN;
              2:       x = 0;
              default: x = -1;
            endcase
            case ($urandom_range(0, 3))
              0:       y = COORD_MAX;
              1:       y = COORD_MIN;
              2:       y = 0;
              default: y = -1;
            endcase
          end
        endcase
        offer_query(x, y, 1'b0, '0);
      end
      in_valid <= 1'b0;
      burst_left = 0;
    end

    // Drain, then give stray words time to show up
    wait_drained();
    repeat (PIPE_STAGES + 10) @(negedge clk);

    $display("Checked %0d result words from %0d queries over %0d box settings (%0d writes).",
             n_checked, n_queries, n_boxes, n_writes);
    $display("Run included a %0d-cycle output hold-off; %0d mismatches counted.",
             HOLD_CYCLES, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/obbcpd_pkg.sv
hw/rtl/obb_closest_point_distance.sv
tb/tb_top.sv
